### design/sca_pkg.sv
`timescale 1ns / 1ps
// sca_pkg: shared types and constants of the slab cell allocator
// no dependencies
package sca_pkg;

    localparam int unsigned PAGES   = 64;
    localparam int unsigned CELLS   = 64;
    localparam int unsigned PG_W    = 6;
    localparam int unsigned CL_W    = 6;
    localparam int unsigned BK_W    = 7;
    localparam int unsigned OFS_W   = 18;
    localparam int unsigned CPP_W   = 7;
    localparam int unsigned CSZ_W   = 13;

    typedef logic [PG_W-1:0]  page_t;
    typedef logic [CL_W-1:0]  cell_t;
    typedef logic [BK_W-1:0]  bucket_t;
    typedef logic [PG_W:0]    link_t;
    typedef logic [CELLS-1:0] bitmap_t;

    localparam link_t LINK_NONE = link_t'(1) << PG_W;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOPAGE  = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam logic REG_CELLS_PER_PAGE = 1'b0;
    localparam logic REG_CELL_SIZE      = 1'b1;

endpackage

### design/sca_if.sv
`timescale 1ns / 1ps
// sca_req_if, sca_rsp_if: request and result channels
// no dependencies
interface sca_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [5:0] page_index;
    logic [5:0] cell_index;
    modport source (output valid, opcode, page_index, cell_index, input ready);
    modport sink (input valid, opcode, page_index, cell_index, output ready);
endinterface

interface sca_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  granted_page;
    logic [5:0]  granted_cell;
    logic [17:0] cell_offset;
    modport source (output valid, status, granted_page, granted_cell, cell_offset,
                    input ready);
    modport sink (input valid, status, granted_page, granted_cell, cell_offset,
                  output ready);
endinterface

### design/sca_cfg_regs.sv
`timescale 1ns / 1ps
// sca_cfg_regs: apb register file for cell count and cell size
// depends on sca_pkg
module sca_cfg_regs
    import sca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [CPP_W-1:0] cells_per_page,
    output logic [CSZ_W-1:0] cell_size
);

    logic [CPP_W-1:0] cpp_reg;
    logic [CSZ_W-1:0] csz_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpp_reg <= CPP_W'(62);
            csz_reg <= CSZ_W'(64);
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_CELLS_PER_PAGE: cpp_reg <= pwdata[CPP_W-1:0];
                REG_CELL_SIZE:      csz_reg <= pwdata[CSZ_W-1:0];
                default:            cpp_reg <= cpp_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CELLS_PER_PAGE: prdata = {{(32-CPP_W){1'b0}}, cpp_reg};
            REG_CELL_SIZE:      prdata = {{(32-CSZ_W){1'b0}}, csz_reg};
            default:            prdata = '0;
        endcase
    end

    assign cells_per_page = cpp_reg;
    assign cell_size      = csz_reg;

endmodule

### design/slab_cell_allocator_core.sv
`timescale 1ns / 1ps
// slab_cell_allocator_core: slab cell allocator over 64 pages of up to 64 cells
// depends on sca_pkg, sca_req_if, sca_rsp_if, sca_cfg_regs
//
// One request is worked at a time. An allocate goes through S_HEAD to reuse a page with
// room or S_RDPG to claim a fresh one, then S_EVAL, the write-backs S_W1, S_W2 and S_W3,
// and S_OUT, which loads the result. A free goes straight to S_EVAL; a rejected free of a
// claimed page goes from S_EVAL to S_OUT, and a free of an unclaimed page or an allocate
// with the pool exhausted straight to S_OUT. The next request is taken in the cycle after
// the result is loaded. The steps are set by the registered reads and write-backs of the
// page bitmap, link and bucket-head memories. The result sits in an output register, so
// the next request is taken while it waits; a second result stalls until the first is
// taken. The bucket memories need no clearing pass: per-bucket occupancy flags reset at
// once, and a page record is written when the page is first claimed.
module slab_cell_allocator_core
    import sca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sca_req_if.sink     req,
    sca_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HEAD = 3'd1;
    localparam logic [2:0] S_RDPG = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_W1   = 3'd4;
    localparam logic [2:0] S_W2   = 3'd5;
    localparam logic [2:0] S_W3   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [CPP_W-1:0] cells_per_page;
    logic [CSZ_W-1:0] cell_size;

    sca_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .cells_per_page (cells_per_page),
        .cell_size      (cell_size)
    );

    // memories
    bitmap_t occ_mem  [PAGES];
    bucket_t used_mem [PAGES];
    link_t   next_mem [PAGES];
    link_t   prev_mem [PAGES];
    page_t   head_mem [CELLS+1];

    bitmap_t occ_rd;
    bucket_t used_rd;
    link_t   next_rd;
    link_t   prev_rd;
    page_t   head_rd;

    logic [2:0]     state_reg, state_next;
    logic [CELLS:0] flag_reg;
    logic [PG_W:0]  claimed_reg;
    logic           op_reg;
    page_t          pg_reg;
    cell_t          cell_reg;
    bucket_t        u_reg, tgt_reg;
    link_t          n_reg, p_reg, h_reg;
    bitmap_t        occ_new_reg;
    logic [1:0]     status_reg;

    logic           ovalid_reg;
    logic [1:0]     ostatus_reg;
    page_t          opage_reg;
    cell_t          ocell_reg;
    logic [OFS_W-1:0] oofs_reg;

    // bucket search
    logic [CPP_W-1:0] active_c;
    logic [CELLS-1:0] search_mask;
    logic             bk_found;
    bucket_t          bk_sel;
    logic             free_found;
    cell_t            free_cell;
    link_t            h_now;

    always_comb
    begin
        if (cells_per_page == '0)
            active_c = CPP_W'(1);
        else if (cells_per_page > CPP_W'(CELLS))
            active_c = CPP_W'(CELLS);
        else
            active_c = cells_per_page;
    end

    always_comb
    begin
        bk_found = 1'b0;
        bk_sel   = '0;
        for (int k = 0; k < CELLS; k++)
        begin
            search_mask[k] = (CPP_W'(k) < active_c);
            if (search_mask[k] && flag_reg[k])
            begin
                bk_found = 1'b1;
                bk_sel   = BK_W'(k);
            end
        end
    end

    always_comb
    begin
        free_found = 1'b0;
        free_cell  = '0;
        for (int k = CELLS-1; k >= 0; k--)
        begin
            if (!occ_rd[k])
            begin
                free_found = 1'b1;
                free_cell  = CL_W'(k);
            end
        end
    end

    assign h_now = flag_reg[tgt_reg] ? {1'b0, head_rd} : LINK_NONE;

    // memory ports
    logic    occ_we, used_we, next_we, prev_we, head_we;
    page_t   occ_wa, used_wa, next_wa, prev_wa, rd_addr;
    bucket_t head_wa, head_ra;
    bitmap_t occ_wd;
    bucket_t used_wd;
    link_t   next_wd, prev_wd;
    page_t   head_wd;
    logic    req_acc;
    logic    fresh;

    assign req_acc = req.valid & req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign fresh = req_acc && (req.opcode == OP_ALLOC) && !bk_found
                   && (claimed_reg < (PG_W+1)'(PAGES));

    always_comb
    begin
        occ_we  = 1'b0; occ_wa  = pg_reg; occ_wd  = occ_new_reg;
        used_we = 1'b0; used_wa = pg_reg; used_wd = tgt_reg;
        next_we = 1'b0; next_wa = pg_reg; next_wd = n_reg;
        prev_we = 1'b0; prev_wa = pg_reg; prev_wd = p_reg;
        head_we = 1'b0; head_wa = u_reg;  head_wd = n_reg[PG_W-1:0];
        head_ra = tgt_reg;
        rd_addr = pg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = req.page_index;
                head_ra = bk_sel;
                if (fresh)
                begin
                    occ_we  = 1'b1; occ_wa  = claimed_reg[PG_W-1:0]; occ_wd = '0;
                    used_we = 1'b1; used_wa = claimed_reg[PG_W-1:0]; used_wd = '0;
                    next_we = 1'b1; next_wa = claimed_reg[PG_W-1:0]; next_wd = LINK_NONE;
                    prev_we = 1'b1; prev_wa = claimed_reg[PG_W-1:0]; prev_wd = LINK_NONE;
                    head_we = 1'b1; head_wa = '0; head_wd = claimed_reg[PG_W-1:0];
                end
            end
            S_HEAD:
                rd_addr = head_rd;
            S_W1:
            begin
                occ_we = 1'b1;
                if (p_reg[PG_W])
                    head_we = 1'b1;
                else
                begin
                    next_we = 1'b1;
                    next_wa = p_reg[PG_W-1:0];
                end
                if (!n_reg[PG_W])
                begin
                    prev_we = 1'b1;
                    prev_wa = n_reg[PG_W-1:0];
                end
            end
            S_W2:
            begin
                used_we = 1'b1;
                next_we = 1'b1; next_wd = h_now;
                prev_we = 1'b1; prev_wd = LINK_NONE;
                head_we = 1'b1; head_wa = tgt_reg; head_wd = pg_reg;
            end
            S_W3:
            begin
                if (!h_reg[PG_W])
                begin
                    prev_we = 1'b1;
                    prev_wa = h_reg[PG_W-1:0];
                    prev_wd = {1'b0, pg_reg};
                end
            end
            default:
                rd_addr = pg_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (occ_we)  occ_mem[occ_wa]   <= occ_wd;
        if (used_we) used_mem[used_wa] <= used_wd;
        if (next_we) next_mem[next_wa] <= next_wd;
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        if (head_we) head_mem[head_wa] <= head_wd;
        occ_rd  <= occ_mem[rd_addr];
        used_rd <= used_mem[rd_addr];
        next_rd <= next_mem[rd_addr];
        prev_rd <= prev_mem[rd_addr];
        head_rd <= head_mem[head_ra];
    end

    // sequencer
    logic out_free;
    assign out_free = !ovalid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    if (req.opcode == OP_FREE)
                        state_next = ((PG_W+1)'(req.page_index) < claimed_reg) ? S_EVAL
                                                                               : S_OUT;
                    else if (bk_found)
                        state_next = S_HEAD;
                    else if (fresh)
                        state_next = S_RDPG;
                    else
                        state_next = S_OUT;
                end
            end
            S_HEAD: state_next = S_EVAL;
            S_RDPG: state_next = S_EVAL;
            S_EVAL:
            begin
                if (op_reg == OP_ALLOC)
                    state_next = (free_found && used_rd < BK_W'(CELLS)) ? S_W1 : S_OUT;
                else
                    state_next = (occ_rd[cell_reg] && used_rd != '0) ? S_W1 : S_OUT;
            end
            S_W1:  state_next = S_W2;
            S_W2:  state_next = S_W3;
            S_W3:  state_next = S_OUT;
            S_OUT: state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            flag_reg    <= '0;
            claimed_reg <= '0;
            ovalid_reg  <= 1'b0;
            status_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_acc)
                    begin
                        if (req.opcode == OP_FREE)
                            status_reg <= ((PG_W+1)'(req.page_index) < claimed_reg)
                                          ? ST_OK : ST_BADFREE;
                        else if (fresh)
                        begin
                            status_reg  <= ST_OK;
                            claimed_reg <= claimed_reg + 1'b1;
                            flag_reg[0] <= 1'b1;
                        end
                        else if (!bk_found)
                            status_reg <= ST_NOPAGE;
                        else
                            status_reg <= ST_OK;
                    end
                end
                S_EVAL:
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        if (!(free_found && used_rd < BK_W'(CELLS)))
                            status_reg <= ST_NOPAGE;
                    end
                    else if (!(occ_rd[cell_reg] && used_rd != '0))
                        status_reg <= ST_BADFREE;
                end
                S_W1:
                begin
                    if (p_reg[PG_W] && n_reg[PG_W])
                        flag_reg[u_reg] <= 1'b0;
                end
                S_W2:
                    flag_reg[tgt_reg] <= 1'b1;
                S_OUT:
                begin
                    if (out_free)
                        ovalid_reg <= 1'b1;
                end
                default:
                    status_reg <= status_reg;
            endcase
            if (ovalid_reg && rsp.ready && !(state_reg == S_OUT))
                ovalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg   <= req.opcode;
                cell_reg <= req.cell_index;
                pg_reg   <= fresh ? claimed_reg[PG_W-1:0] : req.page_index;
            end
            S_HEAD:
                pg_reg <= head_rd;
            S_EVAL:
            begin
                u_reg <= used_rd;
                n_reg <= next_rd;
                p_reg <= prev_rd;
                if (op_reg == OP_ALLOC)
                begin
                    cell_reg    <= free_cell;
                    tgt_reg     <= used_rd + 1'b1;
                    occ_new_reg <= occ_rd | (bitmap_t'(1) << free_cell);
                end
                else
                begin
                    tgt_reg     <= used_rd - 1'b1;
                    occ_new_reg <= occ_rd & ~(bitmap_t'(1) << cell_reg);
                end
            end
            S_W2:
                h_reg <= h_now;
            S_OUT:
            begin
                if (out_free)
                begin
                    ostatus_reg <= status_reg;
                    if (status_reg == ST_OK && op_reg == OP_ALLOC)
                    begin
                        opage_reg <= pg_reg;
                        ocell_reg <= cell_reg;
                        oofs_reg  <= OFS_W'(cell_reg) * OFS_W'(cell_size);
                    end
                    else
                    begin
                        opage_reg <= '0;
                        ocell_reg <= '0;
                        oofs_reg  <= '0;
                    end
                end
            end
            default:
                h_reg <= h_reg;
        endcase
    end

    assign rsp.valid        = ovalid_reg;
    assign rsp.status       = ostatus_reg;
    assign rsp.granted_page = opage_reg;
    assign rsp.granted_cell = ocell_reg;
    assign rsp.cell_offset  = oofs_reg;

endmodule

### design/sca_checker.sv
`timescale 1ns / 1ps
// sca_checker: port-level checks of the slab cell allocator, bound to the top level
// depends on sca_pkg and slab_cell_allocator_core
module sca_checker
    import sca_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [5:0]  rsp_granted_page,
    input logic [5:0]  rsp_granted_cell,
    input logic [17:0] rsp_cell_offset
);

    // a held result keeps its status and granted cell
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_granted_cell))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while one in flight");

    // only an ok allocation carries a grant
    a_zero_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_granted_page == '0
            && rsp_granted_cell == '0 && rsp_cell_offset == '0)
        else $error("grant fields set on error");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_NOPAGE
            || rsp_status == ST_BADFREE)
        else $error("undefined status");

endmodule

bind slab_cell_allocator_core sca_checker u_sca_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_granted_page (rsp.granted_page),
    .rsp_granted_cell (rsp.granted_cell),
    .rsp_cell_offset  (rsp.cell_offset)
);

### bench/sca_tb_if.sv
`timescale 1ns / 1ps
// sca_tb_pkg: expected result record used by the bench scoreboard
// depends on sca_pkg
package sca_tb_pkg;
    import sca_pkg::*;
    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  page;
        logic [5:0]  cell_idx;
        logic [17:0] offset;
    } grant_t;
endpackage

### bench/sca_checker.sv
`timescale 1ns / 1ps
// sca_scoreboard: predicts allocator grants from accepted requests and config writes
// depends on sca_pkg, sca_tb_pkg, sca_req_if, sca_rsp_if
module sca_scoreboard
    import sca_pkg::*;
    import sca_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sca_req_if          req,
    sca_rsp_if          rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);
    bitmap_t     occ [PAGES];
    int          used [PAGES];
    int          nxt [PAGES];
    int          prv [PAGES];
    int          head [CELLS+1];
    int          claimed;
    logic [6:0]  cpp;
    logic [12:0] csz;
    grant_t      grants_due [$];

    function automatic void unlink(int pg);
        int p;
        int n;
        p = prv[pg];
        n = nxt[pg];
        if (p < 0) head[used[pg]] = n;
        else nxt[p] = n;
        if (n >= 0) prv[n] = p;
        nxt[pg] = -1;
        prv[pg] = -1;
    endfunction

    function automatic void push(int pg, int b);
        used[pg] = b;
        prv[pg] = -1;
        nxt[pg] = head[b];
        if (head[b] >= 0) prv[head[b]] = pg;
        head[b] = pg;
    endfunction

    function automatic grant_t predict_grant(logic op, int pin, int cin);
        grant_t g;
        int c;
        int pg;
        int i;
        g = '0;
        c = (cpp == 0) ? 1 : (cpp > CELLS) ? CELLS : int'(cpp);
        if (op == OP_ALLOC)
        begin
            pg = -1;
            for (int b = c - 1; b >= 0; b--)
                if (pg < 0 && head[b] >= 0) pg = head[b];
            if (pg < 0)
            begin
                if (claimed >= PAGES)
                begin
                    g.status = ST_NOPAGE;
                    return g;
                end
                pg = claimed;
                claimed++;
                occ[pg] = '0;
                push(pg, 0);
            end
            i = 0;
            while (i < CELLS && occ[pg][i]) i++;
            if (i >= CELLS || used[pg] >= CELLS)
            begin
                g.status = ST_NOPAGE;
                return g;
            end
            occ[pg][i] = 1'b1;
            c = used[pg] + 1;
            unlink(pg);
            push(pg, c);
            g.status = ST_OK;
            g.page = pg[5:0];
            g.cell_idx = i[5:0];
            g.offset = 18'(i * int'(csz));
        end
        else
        begin
            if (pin >= claimed || !occ[pin][cin] || used[pin] == 0)
            begin
                g.status = ST_BADFREE;
                return g;
            end
            c = used[pin] - 1;
            unlink(pin);
            push(pin, c);
            occ[pin][cin] = 1'b0;
        end
        return g;
    endfunction

    assign pending = grants_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        grant_t e;
        if (!rst_n)
        begin
            for (int p = 0; p < PAGES; p++)
            begin
                occ[p] = '0;
                used[p] = 0;
                nxt[p] = -1;
                prv[p] = -1;
            end
            for (int b = 0; b <= CELLS; b++) head[b] = -1;
            claimed = 0;
            cpp = 7'd62;
            csz = 13'd64;
            fail_count = 0;
            grants_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == REG_CELLS_PER_PAGE) cpp = pwdata[6:0];
                else csz = pwdata[12:0];
            end
            if (rsp.valid && rsp.ready)
            begin
                if (grants_due.size() == 0)
                begin
                    $error("unexpected grant status %0d", rsp.status);
                    fail_count++;
                end
                else
                begin
                    e = grants_due.pop_front();
                    if (rsp.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.granted_page !== e.page)
                    begin
                        $error("granted_page exp %0d got %0d", e.page, rsp.granted_page);
                        fail_count++;
                    end
                    if (rsp.granted_cell !== e.cell_idx)
                    begin
                        $error("granted_cell exp %0d got %0d", e.cell_idx, rsp.granted_cell);
                        fail_count++;
                    end
                    if (rsp.cell_offset !== e.offset)
                    begin
                        $error("cell_offset exp %0d got %0d", e.offset, rsp.cell_offset);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                grants_due.push_back(predict_grant(req.opcode, req.page_index,
                                                   req.cell_index));
        end
    end
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives alloc and free requests and register writes into the allocator
// depends on sca_pkg, sca_tb_pkg, the design interfaces, sca_scoreboard and the core
module tb_top
    import sca_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          send_idle;
    int          recv_stall;
    int          hold_off;
    int          quiet;
    bit          stim_done;

    sca_req_if req ();
    sca_rsp_if rsp ();

    slab_cell_allocator_core dut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    sca_scoreboard chk (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rsp.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            rsp.ready <= 1'b0;
        end
        else rsp.ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) || stim_done)
            quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic sel, int val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // valid stays high after acceptance until the next request or a drain
    task automatic send(logic op, int pg, int cl);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.page_index <= pg[5:0];
        req.cell_index <= cl[5:0];
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending > 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // frees mostly name a cell on one of the first eight pages
    task automatic random_item(int free_pct);
        if ($urandom_range(99) >= free_pct) send(OP_ALLOC, $urandom, $urandom);
        else if ($urandom_range(9) < 8)
            send(OP_FREE, $urandom_range(7), $urandom_range(63));
        else send(OP_FREE, $urandom, $urandom);
    endtask

    task automatic phase(int n, int s, int r, int cpp, int csz, int free_pct);
        drain();
        cfg_write(REG_CELLS_PER_PAGE, cpp);
        cfg_write(REG_CELL_SIZE, csz);
        send_idle = s;
        recv_stall = r;
        for (int i = 0; i < n; i++) random_item(free_pct);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.opcode = OP_ALLOC;
        req.page_index = '0;
        req.cell_index = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
        quiet = 0;
        stim_done = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: bad frees before any page, allocs, frees, error cases
        send(OP_FREE, 0, 0);
        send(OP_FREE, 63, 63);
        send(OP_ALLOC, 63, 63);
        send(OP_ALLOC, 0, 0);
        send(OP_FREE, 0, 1);
        send(OP_FREE, 0, 1);
        send(OP_FREE, 0, 63);
        send(OP_FREE, 5, 0);
        send(OP_ALLOC, 0, 0);
        send(OP_ALLOC, 0, 0);
        drain();
        cfg_write(REG_CELLS_PER_PAGE, 0);
        cfg_write(REG_CELL_SIZE, 0);
        repeat (4) send(OP_ALLOC, 0, 0);
        send(OP_FREE, 1, 0);
        drain();
        cfg_write(REG_CELLS_PER_PAGE, 127);
        cfg_write(REG_CELL_SIZE, 8191);
        repeat (6) send(OP_ALLOC, 42, 21);
        // long hold-off so the output register fills and the input stalls
        drain();
        hold_off = 400;
        repeat (20) random_item(30);
        phase(250, 0, 0, 64, 4096, 40);
        phase(250, 45, 0, 1, 1, 20);
        phase(250, 0, 45, 3, 4095, 45);
        phase(250, 20, 20, 2, 17, 30);
        // exhaust the pool with small pages, then keep hitting the limit
        phase(200, 0, 0, 1, 100, 5);
        phase(200, 45, 45, 64, 64, 50);
        phase(150, 0, 0, 40, 3000, 55);
        drain();
        stim_done = 1;
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
